// File: rtl/pfd_pkg.sv
// Shared types and constants for the PID flow-to-duty controller.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package pfd_pkg;

    localparam int FLOW_W   = 16;
    localparam int ERR_W    = 17;
    localparam int DERIV_W  = 18;
    localparam int ISUM_W   = 40;
    localparam int GAIN_W   = 32;
    localparam int FS_W     = 16;
    localparam int DUTY_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Shared multiplier operands: signed 33 x signed 21
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 21;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Integral is multiplied in two halves, the upper one weighted by 2^ISUM_SPLIT
    localparam int ISUM_SPLIT = 20;
    localparam int ACC_W      = MUL_P_W + ISUM_SPLIT;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FLOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_FULL_SCALE = 3'd4;

    localparam logic [FS_W-1:0] DUTY_FULL_SCALE_RST = 16'd1023;

    // Multiply-accumulate steps
    localparam logic [2:0] MAC_P     = 3'd0;
    localparam logic [2:0] MAC_D     = 3'd1;
    localparam logic [2:0] MAC_I_LO  = 3'd2;
    localparam logic [2:0] MAC_I_HI  = 3'd3;
    localparam logic [2:0] MAC_DRAIN = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INTEG,
        ST_MAC,
        ST_CLAMP,
        ST_SCALE,
        ST_OUT
    } pfd_state_t;

    typedef struct packed {
        logic signed [FLOW_W-1:0] target_flow;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic        [FS_W-1:0]   duty_full_scale;
    } pfd_cfg_t;

endpackage

`default_nettype wire

// File: rtl/pfd_if.sv
// Handshake channels of the controller: sample in, result out, register write.
// Depends on pfd_pkg for field widths.
`default_nettype none

interface pfd_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pfd_pkg::FLOW_W-1:0]    flow_sample;

    modport source (output valid, output flow_sample, input ready);
    modport sink   (input valid, input flow_sample, output ready);
endinterface

interface pfd_result_if;
    logic                                 valid;
    logic                                 ready;
    logic        [pfd_pkg::DUTY_W-1:0]    duty_count;
    logic signed [pfd_pkg::FLOW_W-1:0]    flow_echo;

    modport source (output valid, output duty_count, output flow_echo, input ready);
    modport sink   (input valid, input duty_count, input flow_echo, output ready);
endinterface

interface pfd_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [pfd_pkg::CFG_IDX_W-1:0]        index;
    logic [pfd_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/pfd_cfg_regs.sv
// Configuration register file: set point, three gains and duty full scale.
// Depends on pfd_pkg and the pfd_cfg_if interface.
`default_nettype none

module pfd_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    pfd_cfg_if.sink           cfg,
    output pfd_pkg::pfd_cfg_t regs
);
    import pfd_pkg::*;

    pfd_cfg_t regs_reg;
    pfd_cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_TARGET_FLOW:     regs_next.target_flow     = cfg.data[FLOW_W-1:0];
                REG_GAIN_P:          regs_next.gain_p          = cfg.data;
                REG_GAIN_I:          regs_next.gain_i          = cfg.data;
                REG_GAIN_D:          regs_next.gain_d          = cfg.data;
                REG_DUTY_FULL_SCALE: regs_next.duty_full_scale = cfg.data[FS_W-1:0];
                default:             regs_next = regs_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.target_flow     <= '0;
            regs_reg.gain_p          <= '0;
            regs_reg.gain_i          <= '0;
            regs_reg.gain_d          <= '0;
            regs_reg.duty_full_scale <= DUTY_FULL_SCALE_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pfd_mul.sv
// Shared signed multiplier with a registered product.
// Depends on pfd_pkg for operand widths.
`default_nettype none

module pfd_mul (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [pfd_pkg::MUL_A_W-1:0]   a,
    input  logic signed [pfd_pkg::MUL_B_W-1:0]   b,
    output logic signed [pfd_pkg::MUL_P_W-1:0]  prod
);
    import pfd_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [MUL_P_W-1:0] prod_next;

    assign prod_next = a * b;
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pid_flow_duty_controller.sv
// Top level of the PID flow-to-duty controller: sequencer, integral and accumulator.
// Depends on pfd_pkg, the pfd interfaces, pfd_cfg_regs and pfd_mul.
//
//   channel  dir  payload                     accepted when
//   sample   in   flow_sample                 sample.valid & sample.ready
//   result   out  duty_count, flow_echo       result.valid & result.ready
//   cfg      in   index, data                 cfg.valid & cfg.ready
//
// A sample is taken only in ST_IDLE and runs ST_INTEG, ST_MAC, ST_CLAMP, ST_SCALE and
// ST_OUT, which registers the result, before the next is taken. The sequence is set
// by one shared 33x21 multiplier used five times: three gain terms with the integral
// in two halves, and the duty scaling. Reset clears the integral and last error and
// resets the registers. The finished result waits in its own register, so a new
// sample is taken while it stalls; only a second result finding it full holds back.
`default_nettype none

module pid_flow_duty_controller #(
    parameter int GAIN_FRACTION_BITS = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    pfd_sample_if.sink    sample,
    pfd_result_if.source  result,
    pfd_cfg_if.sink       cfg
);
    import pfd_pkg::*;

    localparam int CLAMP_W = GAIN_FRACTION_BITS + 1;

    pfd_cfg_t regs;

    pfd_state_t                 state_reg,     state_next;
    logic [2:0]                 step_reg,      step_next;
    logic signed [FLOW_W-1:0]   flow_reg,      flow_next;
    logic signed [ERR_W-1:0]    err_reg,       err_next;
    logic signed [ERR_W-1:0]    last_err_reg,  last_err_next;
    logic signed [DERIV_W-1:0]  deriv_reg,     deriv_next;
    logic signed [ISUM_W-1:0]   isum_reg,      isum_next;
    logic signed [ACC_W-1:0]    acc_reg,       acc_next;
    logic [CLAMP_W-1:0]         clamp_reg,     clamp_next;
    logic                       res_valid_reg, res_valid_next;
    logic [DUTY_W-1:0]          duty_reg,      duty_next;
    logic signed [FLOW_W-1:0]   echo_reg,      echo_next;

    logic                       mul_en;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;
    logic signed [ACC_W-1:0]    term;
    logic signed [ISUM_W:0]     isum_wide;
    logic signed [ACC_W-1:0]    one_val;

    pfd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pfd_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    assign sample.ready      = (state_reg == ST_IDLE);
    assign result.valid      = res_valid_reg;
    assign result.duty_count = duty_reg;
    assign result.flow_echo  = echo_reg;

    assign isum_wide = {isum_reg[ISUM_W-1], isum_reg}
                     + {{(ISUM_W + 1 - ERR_W){err_reg[ERR_W-1]}}, err_reg};
    assign one_val   = ACC_W'(1) << GAIN_FRACTION_BITS;

    // Upper integral half carries a weight of 2^ISUM_SPLIT
    always_comb
    begin
        term = ACC_W'(mul_p);
        if (step_reg == MAC_DRAIN)
        begin
            term = ACC_W'(mul_p) <<< ISUM_SPLIT;
        end
    end

    // Operand selection for the shared multiplier
    always_comb
    begin
        mul_a = {regs.gain_p[GAIN_W-1], regs.gain_p};
        mul_b = {{(MUL_B_W - ERR_W){err_reg[ERR_W-1]}}, err_reg};
        if (state_reg == ST_SCALE)
        begin
            mul_a = MUL_A_W'(clamp_reg);
            mul_b = {{(MUL_B_W - FS_W){1'b0}}, regs.duty_full_scale};
        end
        else
        begin
            case (step_reg)
                MAC_P:
                begin
                    mul_a = {regs.gain_p[GAIN_W-1], regs.gain_p};
                    mul_b = {{(MUL_B_W - ERR_W){err_reg[ERR_W-1]}}, err_reg};
                end
                MAC_D:
                begin
                    mul_a = {regs.gain_d[GAIN_W-1], regs.gain_d};
                    mul_b = {{(MUL_B_W - DERIV_W){deriv_reg[DERIV_W-1]}}, deriv_reg};
                end
                MAC_I_LO:
                begin
                    mul_a = {regs.gain_i[GAIN_W-1], regs.gain_i};
                    mul_b = {1'b0, isum_reg[ISUM_SPLIT-1:0]};
                end
                MAC_I_HI:
                begin
                    mul_a = {regs.gain_i[GAIN_W-1], regs.gain_i};
                    mul_b = {isum_reg[ISUM_W-1], isum_reg[ISUM_W-1:ISUM_SPLIT]};
                end
                default:
                begin
                    mul_a = {regs.gain_p[GAIN_W-1], regs.gain_p};
                    mul_b = {{(MUL_B_W - ERR_W){err_reg[ERR_W-1]}}, err_reg};
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        flow_next      = flow_reg;
        err_next       = err_reg;
        last_err_next  = last_err_reg;
        deriv_next     = deriv_reg;
        isum_next      = isum_reg;
        acc_next       = acc_reg;
        clamp_next     = clamp_reg;
        res_valid_next = res_valid_reg;
        duty_next      = duty_reg;
        echo_next      = echo_reg;
        mul_en         = 1'b0;

        if (result.valid && result.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    flow_next  = sample.flow_sample;
                    err_next   = {regs.target_flow[FLOW_W-1], regs.target_flow}
                               - {sample.flow_sample[FLOW_W-1], sample.flow_sample};
                    state_next = ST_INTEG;
                end
            end
            ST_INTEG:
            begin
                // Saturate the integral at the signed 40-bit range
                if (isum_wide[ISUM_W] != isum_wide[ISUM_W-1])
                begin
                    isum_next = isum_wide[ISUM_W] ? {1'b1, {(ISUM_W - 1){1'b0}}}
                                                  : {1'b0, {(ISUM_W - 1){1'b1}}};
                end
                else
                begin
                    isum_next = isum_wide[ISUM_W-1:0];
                end
                deriv_next = {err_reg[ERR_W-1], err_reg}
                           - {last_err_reg[ERR_W-1], last_err_reg};
                acc_next   = '0;
                step_next  = MAC_P;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                // Multiply this step, accumulate the product of the one before
                mul_en = (step_reg != MAC_DRAIN);
                if (step_reg != MAC_P)
                begin
                    acc_next = acc_reg + term;
                end
                if (step_reg == MAC_DRAIN)
                begin
                    state_next = ST_CLAMP;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_CLAMP:
            begin
                if (acc_reg[ACC_W-1])
                begin
                    clamp_next = '0;
                end
                else if (acc_reg > one_val)
                begin
                    clamp_next = CLAMP_W'(one_val);
                end
                else
                begin
                    clamp_next = acc_reg[CLAMP_W-1:0];
                end
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                mul_en     = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold until the result register is free
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    duty_next      = mul_p[GAIN_FRACTION_BITS +: DUTY_W];
                    echo_next      = flow_reg;
                    last_err_next  = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= MAC_P;
            last_err_reg  <= '0;
            isum_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            last_err_reg  <= last_err_next;
            isum_reg      <= isum_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flow_reg  <= flow_next;
        err_reg   <= err_next;
        deriv_reg <= deriv_next;
        acc_reg   <= acc_next;
        clamp_reg <= clamp_next;
        duty_reg  <= duty_next;
        echo_reg  <= echo_next;
    end

endmodule

`default_nettype wire
